FILE: hdl/crls_pkg.sv
// Package for the control record scanner: record and result types, the record
// magic and erased word, and the CRC-32 column constants for the XOR network.
// Depends on nothing; the CRC network, the scan core and the top level use it.
package crls_pkg;

  localparam logic [31:0] CTRL_MAGIC  = 32'h434F_4E54;
  localparam logic [31:0] ERASED_WORD = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;

  // Scan status codes carried in the result word.
  localparam logic        SCAN_OK         = 1'b0;
  localparam logic        SCAN_READ_ERROR = 1'b1;

  // Data bits covered by the network: magic, sequence, active and pending.
  localparam int DataBits = 128;
  // The zeroed check word that closes the CRC stream.
  localparam int TailBits = 32;

  typedef struct packed {
    logic [31:0] record_magic;
    logic [31:0] record_sequence;
    logic [31:0] record_active;
    logic [31:0] record_pending;
    logic [31:0] record_check;
    logic        read_failed;
    logic        block_end;
  } rec_t;

  typedef struct packed {
    logic        scan_status;
    logic        record_found;
    logic [31:0] latest_sequence;
    logic [31:0] latest_active;
    logic [31:0] latest_pending;
  } res_t;

  // Status passed from the scan core back to the stage control.
  typedef struct packed {
    logic emit;
    logic finished;
  } scan_stat_t;

  typedef logic [DataBits-1:0][31:0] crc_cols_t;

  // Bit-serial reflected CRC over the data bits, least significant bit of the
  // magic first, followed by the zero check word. Only evaluated at
  // elaboration to build the constants below.
  function automatic logic [31:0] crc_stream(logic [31:0] init, logic [DataBits-1:0] data);
    logic [31:0] c;
    logic        fb;
    c = init;
    for (int j = 0; j < DataBits; j++) begin
      fb = c[0] ^ data[j];
      c  = {1'b0, c[31:1]} ^ (fb ? CRC_POLY : 32'h0);
    end
    for (int j = 0; j < TailBits; j++) begin
      fb = c[0];
      c  = {1'b0, c[31:1]} ^ (fb ? CRC_POLY : 32'h0);
    end
    return c;
  endfunction

  // The CRC is affine in the data: each data bit flips a fixed column.
  function automatic crc_cols_t crc_columns();
    crc_cols_t cols;
    for (int i = 0; i < DataBits; i++) begin
      cols[i] = crc_stream(32'h0, DataBits'(1) << i);
    end
    return cols;
  endfunction

  localparam crc_cols_t   CRC_COLS = crc_columns();
  localparam logic [31:0] CRC_BASE = crc_stream(32'hFFFF_FFFF, '0) ^ 32'hFFFF_FFFF;

endpackage

FILE: hdl/crls_rec_if.sv
// Record channel interface: valid, ready and the fields of one record word.
// Stands alone; used by the top level of the control record scanner.
interface crls_rec_if;
  logic        valid;
  logic        ready;
  logic [31:0] record_magic;
  logic [31:0] record_sequence;
  logic [31:0] record_active;
  logic [31:0] record_pending;
  logic [31:0] record_check;
  logic        read_failed;
  logic        block_end;

  modport source (
    output valid, record_magic, record_sequence, record_active, record_pending,
           record_check, read_failed, block_end,
    input  ready
  );

  modport sink (
    input  valid, record_magic, record_sequence, record_active, record_pending,
           record_check, read_failed, block_end,
    output ready
  );
endinterface

FILE: hdl/crls_res_if.sv
// Result channel interface: valid, ready and the fields of one scan result word.
// Stands alone; used by the top level of the control record scanner.
interface crls_res_if;
  logic        valid;
  logic        ready;
  logic        scan_status;
  logic        record_found;
  logic [31:0] latest_sequence;
  logic [31:0] latest_active;
  logic [31:0] latest_pending;

  modport source (
    output valid, scan_status, record_found, latest_sequence, latest_active,
           latest_pending,
    input  ready
  );

  modport sink (
    input  valid, scan_status, record_found, latest_sequence, latest_active,
           latest_pending,
    output ready
  );
endinterface

FILE: hdl/crls_crc32.sv
// CRC-32 of a control record as a flat XOR network over 128 data bits.
// Depends on crls_pkg for the column constants.
module crls_crc32 (
  input  logic [crls_pkg::DataBits-1:0] data,
  output logic [31:0]                   crc
);

  always_comb begin
    crc = crls_pkg::CRC_BASE;
    for (int i = 0; i < crls_pkg::DataBits; i++) begin
      crc = crc ^ (crls_pkg::CRC_COLS[i] & {32{data[i]}});
    end
  end

endmodule

FILE: hdl/crls_scan_core.sv
// Scan core: classifies the staged record, keeps the best record so far and
// forms the result word. Depends on crls_pkg and crls_crc32.
module crls_scan_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  crls_pkg::rec_t      rec,
  output crls_pkg::res_t      res,
  output crls_pkg::scan_stat_t stat
);

  logic        have_best_r, have_best_nxt;
  logic        finished_r, finished_nxt;
  logic [31:0] best_seq_r, best_act_r, best_pend_r;
  logic [31:0] crc;
  logic        rec_ok, erased, take;
  logic        upd_have;
  logic [31:0] upd_seq, upd_act, upd_pend;
  logic        status, found;

  crls_crc32 u_crc (
    .data ({rec.record_pending, rec.record_active, rec.record_sequence, rec.record_magic}),
    .crc  (crc)
  );

  assign rec_ok = (rec.record_magic == crls_pkg::CTRL_MAGIC) && (crc == rec.record_check);
  assign erased = (rec.record_magic == crls_pkg::ERASED_WORD) &&
                  (rec.record_sequence == crls_pkg::ERASED_WORD);
  // An erased record can never pass the magic check, so take is only set on
  // the ordinary path.
  assign take   = !finished_r && !rec.read_failed && rec_ok &&
                  (!have_best_r || (rec.record_sequence > best_seq_r));

  assign upd_have = have_best_r | take;
  assign upd_seq  = take ? rec.record_sequence : best_seq_r;
  assign upd_act  = take ? rec.record_active   : best_act_r;
  assign upd_pend = take ? rec.record_pending  : best_pend_r;

  always_comb begin
    stat.emit     = 1'b0;
    stat.finished = finished_r;
    status        = crls_pkg::SCAN_OK;
    priority if (finished_r) begin
      stat.emit = 1'b0;
    end else if (rec.read_failed) begin
      stat.emit = 1'b1;
      status    = crls_pkg::SCAN_READ_ERROR;
    end else if (erased) begin
      stat.emit = 1'b1;
    end else begin
      stat.emit = rec.block_end;
    end
  end

  assign found               = (status == crls_pkg::SCAN_OK) && upd_have;
  assign res.scan_status     = status;
  assign res.record_found    = found;
  assign res.latest_sequence = found ? upd_seq  : 32'h0;
  assign res.latest_active   = found ? upd_act  : crls_pkg::ERASED_WORD;
  assign res.latest_pending  = found ? upd_pend : crls_pkg::ERASED_WORD;

  always_comb begin
    have_best_nxt = have_best_r;
    finished_nxt  = finished_r;
    if (fire) begin
      if (rec.block_end) begin
        have_best_nxt = 1'b0;
        finished_nxt  = 1'b0;
      end else begin
        have_best_nxt = upd_have;
        finished_nxt  = finished_r | rec.read_failed | erased;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_best_r <= 1'b0;
      finished_r  <= 1'b0;
    end else begin
      have_best_r <= have_best_nxt;
      finished_r  <= finished_nxt;
    end
  end

  // The best words only matter while have_best_r is set.
  always_ff @(posedge clk) begin
    if (fire && take) begin
      best_seq_r  <= rec.record_sequence;
      best_act_r  <= rec.record_active;
      best_pend_r <= rec.record_pending;
    end
  end

endmodule

FILE: hdl/control_record_latest_scan.sv
// Control record scanner, top level: input register, scan core, result register.
// An accepted word is held in the input register; its result, if it gives one, then goes to the result register.
// Throughput: one record word per cycle, limited only by a stalled result register.
// Reset (rst_n low, synchronous) empties both registers and clears the scan state.
// Depends on crls_pkg, crls_rec_if, crls_res_if, crls_scan_core and crls_crc32.
module control_record_latest_scan (
  input  logic            clk,
  input  logic            rst_n,
  crls_rec_if.sink        in_rec,
  crls_res_if.source      out_res
);

  // Stage one holds the record word while the core looks at it. The core is
  // purely combinational apart from its scan state, so the whole check of a
  // record (CRC network, magic compare, sequence compare) sits between the
  // stage one register and the result register.
  logic                 s1_valid_r, s1_valid_nxt;
  crls_pkg::rec_t       s1_rec_r;
  logic                 out_valid_r, out_valid_nxt;
  crls_pkg::res_t       out_res_r;
  crls_pkg::res_t       res;
  crls_pkg::scan_stat_t stat;
  logic                 in_fire, out_free, s1_go;

  // The result register can take a new word when it is empty or is being
  // drained in this cycle.
  assign out_free = !out_valid_r || out_res.ready;
  // A staged word that gives no result always moves on; one that gives a
  // result waits only for room in the result register.
  assign s1_go    = s1_valid_r && (!stat.emit || out_free);
  assign in_rec.ready = !s1_valid_r || s1_go;
  assign in_fire  = in_rec.valid && in_rec.ready;

  crls_scan_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (s1_go),
    .rec   (s1_rec_r),
    .res   (res),
    .stat  (stat)
  );

  assign s1_valid_nxt = in_fire || (s1_valid_r && !s1_go);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_go && stat.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_res.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset; their valid flags guard them.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_rec_r.record_magic    <= in_rec.record_magic;
      s1_rec_r.record_sequence <= in_rec.record_sequence;
      s1_rec_r.record_active   <= in_rec.record_active;
      s1_rec_r.record_pending  <= in_rec.record_pending;
      s1_rec_r.record_check    <= in_rec.record_check;
      s1_rec_r.read_failed     <= in_rec.read_failed;
      s1_rec_r.block_end       <= in_rec.block_end;
    end
    if (s1_go && stat.emit) begin
      out_res_r <= res;
    end
  end

  assign out_res.valid           = out_valid_r;
  assign out_res.scan_status     = out_res_r.scan_status;
  assign out_res.record_found    = out_res_r.record_found;
  assign out_res.latest_sequence = out_res_r.latest_sequence;
  assign out_res.latest_active   = out_res_r.latest_active;
  assign out_res.latest_pending  = out_res_r.latest_pending;

`ifndef NO_ASSERTIONS
  // The input side stalls only behind a staged result that cannot be stored.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_rec.ready |-> (s1_valid_r && stat.emit && out_valid_r && !out_res.ready))
    else $error("input stalled without a blocked result");

  // A read error result never reports a record.
  a_err_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_res.valid && out_res.scan_status) |->
      (!out_res.record_found && (out_res.latest_sequence == 32'h0)))
    else $error("read error result carries a record");

  // A word that leaves stage one with a result shows it in the next cycle.
  a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && stat.emit) |=> out_res.valid)
    else $error("result lost on the way to the result register");

  // Once a scan has ended, no further result appears until the block ends.
  a_quiet_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    stat.finished |-> !stat.emit)
    else $error("result given after the scan ended");
`endif

endmodule
